// ===== hw/rtl/peqh_pkg.sv =====
// Package of shared constants, codes and types for the presence event queue.
`timescale 1ns / 1ps

package peqh_pkg;

    // Default values of the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int CLASS_BITS_DEF  = 16;

    // Reset values of the programmable and architectural state.
    localparam logic [15:0] HB_MS_RESET = 16'd1000;
    localparam logic [31:0] SEQ_START   = 32'd1;

    // Stream widths.
    localparam int S_TDATA_W = 232;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 304;
    localparam int M_TUSER_W = 4;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_SUBMIT  = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_ENABLE  = 2'd2;

    // Result status codes carried in the output tuser.
    localparam logic [2:0] RES_NONE   = 3'd0;
    localparam logic [2:0] RES_CHANGE = 3'd1;
    localparam logic [2:0] RES_HEART  = 3'd2;
    localparam logic [2:0] RES_DEQ    = 3'd3;
    localparam logic [2:0] RES_EMPTY  = 3'd4;
    localparam logic [2:0] RES_ENABLE = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } peqh_cmd_t;

endpackage

// ===== hw/rtl/peqh_ctrl.sv =====
// Controller state machine that sequences capture, execution and result loading.
`timescale 1ns / 1ps

module peqh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                out_free,
    output peqh_pkg::peqh_cmd_t cmd
);
    import peqh_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next-state logic: one word is taken, executed, then handed to the output register.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    assign s_tready    = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.execute = (state_reg == S_EXEC);
    assign cmd.load    = (state_reg == S_DONE) && out_free;

endmodule

// ===== hw/rtl/peqh_dp.sv =====
// Datapath: input latch, event detection, two-part slot memory, counters and output register.
`timescale 1ns / 1ps

module peqh_dp #(
    parameter int QUEUE_DEPTH = peqh_pkg::QUEUE_DEPTH_DEF,
    parameter int CLASS_BITS  = peqh_pkg::CLASS_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  peqh_pkg::peqh_cmd_t             cmd,
    input  logic [peqh_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [peqh_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,
    input  logic                            m_tready,
    output logic                            out_free,
    output logic                            m_tvalid,
    output logic [peqh_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [peqh_pkg::M_TUSER_W-1:0]  m_tuser
);
    import peqh_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = PW + 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW:0]   DEPTH_C  = (CW + 1)'(QUEUE_DEPTH);

    // One queued event as held in the slot memory.
    typedef struct packed {
        logic [6:0]  conf;
        logic [31:0] seq;
        logic [63:0] counts;
        logic [15:0] exited;
        logic [15:0] entered;
        logic [15:0] present;
        logic [47:0] stamp;
        logic [63:0] frame;
    } entry_t;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    // Latched input word.
    logic [1:0]            cmd_reg;
    logic [31:0]           now_reg;
    logic [63:0]           frame_reg;
    logic [47:0]           stamp_reg;
    logic [CLASS_BITS-1:0] mask_reg;
    logic [63:0]           counts_reg;
    logic [6:0]            conf_reg;
    logic                  en_reg;

    // Architectural state.
    logic [15:0]           hb_ms_reg;
    logic                  enabled_reg, enabled_next;
    logic                  seen_reg, seen_next;
    logic [CLASS_BITS-1:0] prior_reg, prior_next;
    logic                  queued_reg, queued_next;
    logic [31:0]           last_time_reg, last_time_next;
    logic [31:0]           seq_reg, seq_next;
    logic [31:0]           drops_reg, drops_next;

    // Change events and heartbeats sit in two rings; heartbeats always queue behind changes.
    logic [PW-1:0] chg_head_reg, chg_head_next;
    logic [PW-1:0] chg_tail_reg, chg_tail_next;
    logic [CW-1:0] chg_cnt_reg, chg_cnt_next;
    logic [PW-1:0] hb_head_reg, hb_head_next;
    logic [PW-1:0] hb_tail_reg, hb_tail_next;
    logic [CW-1:0] hb_cnt_reg, hb_cnt_next;

    logic [2:0] status_reg, status_next;
    logic       pick_hb_reg, pick_hb_next;

    // Slot memory.
    entry_t        slot_mem [0:(1 << AW)-1];
    entry_t        rd_data_reg;
    entry_t        wr_data;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    // Event detection terms.
    logic [CLASS_BITS-1:0] prev_mask, entered, exited;
    logic                  changed, hb_evt;
    logic [31:0]           elapsed;
    logic [CW:0]           total_cnt, kept_cnt, drop_add;
    logic                  full_q, evict_hb;
    logic [32:0]           drop_sum;

    // Output register.
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic [M_TDATA_W-1:0] out_word;
    logic [3:0]           fill_ext;
    logic                 is_deq;

    // Input latch.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg    <= s_tuser;
            now_reg    <= s_tdata[31:0];
            frame_reg  <= s_tdata[95:32];
            stamp_reg  <= s_tdata[143:96];
            mask_reg   <= s_tdata[144 +: CLASS_BITS];
            counts_reg <= s_tdata[223:160];
            conf_reg   <= s_tdata[230:224];
            en_reg     <= s_tdata[231];
        end
    end

    // Change and heartbeat detection, and the queue occupancy seen by the new event.
    always_comb begin
        prev_mask = seen_reg ? prior_reg : '0;
        changed   = (mask_reg != prev_mask);
        entered   = mask_reg & ~prev_mask;
        exited    = prev_mask & ~mask_reg;
        elapsed   = now_reg - last_time_reg;
        hb_evt    = !changed && (mask_reg != '0) && queued_reg
                    && (elapsed >= {16'd0, hb_ms_reg});
        total_cnt = {1'b0, chg_cnt_reg} + {1'b0, hb_cnt_reg};
        kept_cnt  = changed ? {1'b0, chg_cnt_reg} : total_cnt;
        full_q    = (kept_cnt >= DEPTH_C);
        evict_hb  = full_q && !changed && (hb_cnt_reg != '0);
    end

    // Entry written for a new event.
    always_comb begin
        wr_data.conf    = conf_reg;
        wr_data.seq     = seq_reg;
        wr_data.counts  = counts_reg;
        wr_data.exited  = changed ? 16'(exited) : 16'd0;
        wr_data.entered = changed ? 16'(entered) : 16'd0;
        wr_data.present = 16'(mask_reg);
        wr_data.stamp   = stamp_reg;
        wr_data.frame   = frame_reg;
    end

    // Execution of one command.
    always_comb begin
        enabled_next   = enabled_reg;
        seen_next      = seen_reg;
        prior_next     = prior_reg;
        queued_next    = queued_reg;
        last_time_next = last_time_reg;
        seq_next       = seq_reg;
        chg_head_next  = chg_head_reg;
        chg_tail_next  = chg_tail_reg;
        chg_cnt_next   = chg_cnt_reg;
        hb_head_next   = hb_head_reg;
        hb_tail_next   = hb_tail_reg;
        hb_cnt_next    = hb_cnt_reg;
        status_next    = status_reg;
        pick_hb_next   = pick_hb_reg;
        drop_add       = '0;
        mem_we         = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (cmd.execute) begin
            status_next  = RES_NONE;
            pick_hb_next = 1'b0;
            case (cmd_reg)
                CMD_SUBMIT: begin
                    if (enabled_reg) begin
                        seen_next  = 1'b1;
                        prior_next = mask_reg;
                        if (changed || hb_evt) begin
                            seq_next       = seq_reg + 32'd1;
                            last_time_next = now_reg;
                            queued_next    = 1'b1;
                            status_next    = hb_evt ? RES_HEART : RES_CHANGE;
                            drop_add       = (changed ? {1'b0, hb_cnt_reg} : '0)
                                             + {{CW{1'b0}}, full_q};
                            // A change event purges every queued heartbeat.
                            if (changed) begin
                                hb_cnt_next  = '0;
                                hb_head_next = hb_tail_reg;
                            end
                            // A full queue loses its oldest heartbeat, or else its head.
                            if (full_q) begin
                                if (evict_hb) begin
                                    hb_head_next = ptr_inc(hb_head_reg);
                                    hb_cnt_next  = hb_cnt_reg - 1'b1;
                                end else begin
                                    chg_head_next = ptr_inc(chg_head_reg);
                                    chg_cnt_next  = chg_cnt_reg - 1'b1;
                                end
                            end
                            // Append the new event at the tail of its ring.
                            mem_we = 1'b1;
                            if (hb_evt) begin
                                wr_addr      = {1'b1, hb_tail_reg};
                                hb_tail_next = ptr_inc(hb_tail_reg);
                                hb_cnt_next  = hb_cnt_next + 1'b1;
                            end else begin
                                wr_addr       = {1'b0, chg_tail_reg};
                                chg_tail_next = ptr_inc(chg_tail_reg);
                                chg_cnt_next  = chg_cnt_next + 1'b1;
                            end
                        end
                    end
                end
                CMD_DEQUEUE: begin
                    if (total_cnt == '0) begin
                        status_next = RES_EMPTY;
                    end else begin
                        status_next = RES_DEQ;
                        rd_en       = 1'b1;
                        if (chg_cnt_reg != '0) begin
                            rd_addr       = {1'b0, chg_head_reg};
                            chg_head_next = ptr_inc(chg_head_reg);
                            chg_cnt_next  = chg_cnt_reg - 1'b1;
                        end else begin
                            pick_hb_next = 1'b1;
                            rd_addr      = {1'b1, hb_head_reg};
                            hb_head_next = ptr_inc(hb_head_reg);
                            hb_cnt_next  = hb_cnt_reg - 1'b1;
                        end
                    end
                end
                CMD_ENABLE: begin
                    status_next  = RES_ENABLE;
                    enabled_next = en_reg;
                    // Disabling flushes the queue and forgets the mask history.
                    if (!en_reg) begin
                        drop_add      = total_cnt;
                        chg_cnt_next  = '0;
                        chg_head_next = chg_tail_reg;
                        hb_cnt_next   = '0;
                        hb_head_next  = hb_tail_reg;
                        seen_next     = 1'b0;
                        prior_next    = '0;
                        queued_next   = 1'b0;
                    end
                end
                default: begin
                    status_next = RES_NONE;
                end
            endcase
        end

        // Saturating drop counter.
        drop_sum   = {1'b0, drops_reg} + 33'(drop_add);
        drops_next = drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];
    end

    // Control and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_ms_reg     <= HB_MS_RESET;
            enabled_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            prior_reg     <= '0;
            queued_reg    <= 1'b0;
            last_time_reg <= '0;
            seq_reg       <= SEQ_START;
            drops_reg     <= '0;
            chg_head_reg  <= '0;
            chg_tail_reg  <= '0;
            chg_cnt_reg   <= '0;
            hb_head_reg   <= '0;
            hb_tail_reg   <= '0;
            hb_cnt_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                hb_ms_reg <= cfg_wr_data;
            end
            enabled_reg   <= enabled_next;
            seen_reg      <= seen_next;
            prior_reg     <= prior_next;
            queued_reg    <= queued_next;
            last_time_reg <= last_time_next;
            seq_reg       <= seq_next;
            drops_reg     <= drops_next;
            chg_head_reg  <= chg_head_next;
            chg_tail_reg  <= chg_tail_next;
            chg_cnt_reg   <= chg_cnt_next;
            hb_head_reg   <= hb_head_next;
            hb_tail_reg   <= hb_tail_next;
            hb_cnt_reg    <= hb_cnt_next;
        end
    end

    // Per-word result registers.
    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        pick_hb_reg <= pick_hb_next;
    end

    // Slot memory write and registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // Result word assembly; packet fields stay zero unless a packet was dequeued.
    always_comb begin
        is_deq   = (status_reg == RES_DEQ);
        fill_ext = 4'(total_cnt);
        out_word = '0;
        if (is_deq) begin
            out_word[31:0]    = rd_data_reg.seq;
            out_word[95:32]   = rd_data_reg.frame;
            out_word[143:96]  = rd_data_reg.stamp;
            out_word[159:144] = rd_data_reg.present;
            out_word[175:160] = rd_data_reg.entered;
            out_word[191:176] = rd_data_reg.exited;
            out_word[255:192] = rd_data_reg.counts;
            out_word[262:256] = rd_data_reg.conf;
        end
        out_word[266:263] = fill_ext;
        out_word[298:267] = drops_reg;
    end

    // Output register: loaded when free, emptied when the receiver takes the word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg <= out_word;
            m_user_reg <= {is_deq && pick_hb_reg, status_reg};
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hw/rtl/presence_event_queue_heartbeat.sv =====
// Top level of the presence event queue with heartbeat events.
// Usage:
//   Input words arrive on the s_ stream; tuser carries the command (submit a frame
//   summary, dequeue the head packet, set enable). Every accepted word produces
//   exactly one result word on the m_ stream, with a status code in tuser and the
//   dequeued packet, queue fill and drop total in tdata.
//   The heartbeat interval is written through cfg_wr_en and cfg_wr_data while idle.
//   The user must keep to this; the block itself does not enforce it.
// Sequence:
//   A word is latched when accepted, executed in the EXEC state (event detection,
//   queue update and slot memory access) and loaded into the output register in
//   the DONE state once that register is free; only then is a new word accepted.
// Reset:
//   aresetn clears the queue, disables the block, sets the next sequence number
//   to one and the heartbeat interval to 1000 ms. The slot memory is not cleared.
// Stalls:
//   One finished word waits in the output register; a further word is accepted and
//   executed meanwhile, and then waits until the receiver takes the first.
`timescale 1ns / 1ps

module presence_event_queue_heartbeat #(
    parameter int QUEUE_DEPTH = peqh_pkg::QUEUE_DEPTH_DEF,
    parameter int CLASS_BITS  = peqh_pkg::CLASS_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms[31:0], frame_number[95:32], timestamp_ms[143:96], class_mask[159:144],
    // class_counts[223:160], peak_confidence[230:224], enable_value[231]
    input  logic [peqh_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [peqh_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           cfg_wr_en,
    input  logic [15:0]                    cfg_wr_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sequence_res[31:0], out_frame_number[95:32], out_timestamp_ms[143:96],
    // present_bits[159:144], entered_bits[175:160], exited_bits[191:176],
    // out_class_counts[255:192], out_peak_confidence[262:256], queue_fill[266:263],
    // replaced_total[298:267], zero padding[303:299]
    output logic [peqh_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0], is_heartbeat[3]
    output logic [peqh_pkg::M_TUSER_W-1:0] m_tuser
);
    import peqh_pkg::*;

    peqh_cmd_t dp_cmd;
    logic      out_free;

    // Controller.
    peqh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .cmd      (dp_cmd)
    );

    // Datapath.
    peqh_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CLASS_BITS  (CLASS_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (dp_cmd),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .out_free    (out_free),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // An accepted word is executed in the following cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> dp_cmd.execute)
        else $error("accepted word was not executed");

    // A result is only loaded when the output register can take it, and then shows.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.load |=> m_tvalid)
        else $error("loaded result not presented");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:0] <= RES_ENABLE))
        else $error("undefined status code");

    // The heartbeat flag only accompanies a dequeued packet.
    a_hb_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == RES_DEQ))
        else $error("heartbeat flag without dequeue");

endmodule

// ===== tb/presence_event_queue_heartbeat_test.sv =====
// Self-checking testbench for the presence event queue with heartbeat events.
`timescale 1ns / 1ps

module presence_event_queue_heartbeat_test;
    import peqh_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         SLOT_COUNT  = QUEUE_DEPTH_DEF;
    localparam int         STALL_LIMIT = 5000;
    localparam int         PRINT_LIMIT = 100;

    // One input word as the sender sees it.
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [63:0] frame;
        logic [47:0] stamp;
        logic [15:0] mask;
        logic [63:0] counts;
        logic [6:0]  conf;
        logic        enable;
    } summary_word_t;

    // One queued presence event.
    typedef struct {
        logic [63:0] frame;
        logic [47:0] stamp;
        logic [15:0] present;
        logic [15:0] entered;
        logic [15:0] exited;
        logic [63:0] counts;
        logic [31:0] seq;
        logic        beat;
        logic [6:0]  conf;
    } event_slot_t;

    // One result word, unpacked.
    typedef struct {
        logic [2:0]  status;
        logic        beat;
        logic [31:0] seq;
        logic [63:0] frame;
        logic [47:0] stamp;
        logic [15:0] present;
        logic [15:0] entered;
        logic [15:0] exited;
        logic [63:0] counts;
        logic [6:0]  conf;
        logic [3:0]  fill;
        logic [31:0] drops;
    } outcome_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 cfg_wr_en = 1'b0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Words waiting to be sent and results waiting to arrive.
    summary_word_t pending_words[$];
    summary_word_t word_on_bus;
    outcome_t      outcome_words_due[$];

    // Own copy of the block's state.
    event_slot_t   model_slots[$];
    logic          model_enabled = 1'b0;
    logic          model_seen = 1'b0;
    logic [15:0]   model_prior = '0;
    logic          model_queued_once = 1'b0;
    logic [31:0]   model_last_event = '0;
    logic [31:0]   model_next_seq = SEQ_START;
    logic [31:0]   model_drops = '0;
    logic [15:0]   model_interval = HB_MS_RESET;

    // Stimulus generator state.
    logic [31:0]   gen_now = '0;
    logic [15:0]   gen_mask = '0;
    logic          gen_enabled = 1'b0;

    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;

    presence_event_queue_heartbeat dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Free-running clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Drop counter saturates at all ones.
    task automatic add_drops(input logic [31:0] n);
        if (n > 32'hFFFF_FFFF - model_drops) begin
            model_drops = 32'hFFFF_FFFF;
        end else begin
            model_drops = model_drops + n;
        end
    endtask

    // A change event purges heartbeats; a full queue loses its oldest heartbeat or its head.
    task automatic store_event(input event_slot_t ev);
        int  i;
        logic gone;
        if (!ev.beat) begin
            i = 0;
            while (i < model_slots.size()) begin
                if (model_slots[i].beat) begin
                    model_slots.delete(i);
                    add_drops(32'd1);
                end else begin
                    i++;
                end
            end
        end
        if (model_slots.size() >= SLOT_COUNT) begin
            gone = 1'b0;
            for (i = 0; i < model_slots.size(); i++) begin
                if (model_slots[i].beat) begin
                    model_slots.delete(i);
                    gone = 1'b1;
                    break;
                end
            end
            if (!gone) begin
                model_slots.delete(0);
            end
            add_drops(32'd1);
        end
        model_slots.insert(model_slots.size(), ev);
    endtask

    // Works out the result of one accepted word and updates the model state.
    task automatic step_event_queue(input summary_word_t w);
        outcome_t    r;
        event_slot_t ev;
        logic [15:0] prev;
        logic        changed;
        logic        beat;
        r = '{default: '0};
        case (w.cmd)
            CMD_SUBMIT: begin
                if (model_enabled) begin
                    prev = model_seen ? model_prior : 16'h0;
                    changed = (w.mask != prev);
                    beat = 1'b0;
                    model_seen = 1'b1;
                    model_prior = w.mask;
                    if (!changed && w.mask != 16'h0 && model_queued_once) begin
                        beat = (32'(w.now_ms - model_last_event) >= {16'h0, model_interval});
                    end
                    if (changed || beat) begin
                        ev.frame = w.frame;
                        ev.stamp = w.stamp;
                        ev.present = w.mask;
                        ev.entered = changed ? (w.mask & ~prev) : 16'h0;
                        ev.exited = changed ? (prev & ~w.mask) : 16'h0;
                        ev.counts = w.counts;
                        ev.seq = model_next_seq;
                        ev.beat = beat;
                        ev.conf = w.conf;
                        model_next_seq = model_next_seq + 32'd1;
                        store_event(ev);
                        model_last_event = w.now_ms;
                        model_queued_once = 1'b1;
                        r.status = beat ? RES_HEART : RES_CHANGE;
                    end
                end
            end
            CMD_DEQUEUE: begin
                if (model_slots.size() == 0) begin
                    r.status = RES_EMPTY;
                end else begin
                    ev = model_slots[0];
                    model_slots.delete(0);
                    r.status = RES_DEQ;
                    r.beat = ev.beat;
                    r.seq = ev.seq;
                    r.frame = ev.frame;
                    r.stamp = ev.stamp;
                    r.present = ev.present;
                    r.entered = ev.entered;
                    r.exited = ev.exited;
                    r.counts = ev.counts;
                    r.conf = ev.conf;
                end
            end
            CMD_ENABLE: begin
                r.status = RES_ENABLE;
                model_enabled = w.enable;
                if (!w.enable) begin
                    add_drops(32'(model_slots.size()));
                    model_slots.delete();
                    model_seen = 1'b0;
                    model_prior = 16'h0;
                    model_queued_once = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.fill = 4'(model_slots.size());
        r.drops = model_drops;
        outcome_words_due.insert(outcome_words_due.size(), r);
    endtask

    // Word with the given control fields and a random payload.
    function automatic summary_word_t make_word(input logic [1:0] cmd, input logic [31:0] now,
                                                input logic [15:0] mask, input logic en);
        summary_word_t w;
        w.cmd = cmd;
        w.now_ms = now;
        w.mask = mask;
        w.enable = en;
        w.frame = {$urandom, $urandom};
        w.stamp = 48'({$urandom, $urandom});
        w.counts = {$urandom, $urandom};
        w.conf = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 101)) : 7'($urandom_range(100));
        return w;
    endfunction

    // Appends a word to the sender's list.
    task automatic queue_word(input summary_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // Random word: the mask mostly holds steady and time moves on at a pace that lets
    // heartbeats fire, with some noise in both.
    task automatic push_random_word(input int deq_pct);
        summary_word_t w;
        int roll;
        int pick;
        roll = $urandom_range(99);
        if (roll >= 60 && roll < 75) begin
            gen_mask = gen_mask ^ (16'h1 << $urandom_range(15));
        end else if (roll >= 75 && roll < 85) begin
            gen_mask = 16'($urandom);
        end else if (roll >= 85 && roll < 95) begin
            gen_mask = 16'h0;
        end else if (roll >= 95) begin
            gen_mask = 16'hFFFF;
        end
        gen_now = gen_now + 32'($urandom_range(model_interval / 3 + 2, 0));
        if ($urandom_range(49) == 0) begin
            gen_now = $urandom;
        end
        pick = $urandom_range(99);
        if (!gen_enabled && pick < 80) begin
            w = make_word(CMD_ENABLE, gen_now, gen_mask, 1'b1);
        end else if (pick < 2) begin
            w = make_word(CMD_UNUSED, gen_now, gen_mask, 1'($urandom));
        end else if (pick < 5) begin
            w = make_word(CMD_ENABLE, gen_now, gen_mask, $urandom_range(99) < 60);
        end else if (pick < 5 + deq_pct) begin
            w = make_word(CMD_DEQUEUE, gen_now, gen_mask, 1'($urandom));
        end else begin
            w = make_word(CMD_SUBMIT, gen_now, gen_mask, 1'($urandom));
        end
        if (w.cmd == CMD_ENABLE) begin
            gen_enabled = w.enable;
        end
        queue_word(w);
    endtask

    // Holds until every word is sent and every result has arrived.
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || outcome_words_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_interval(input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        model_interval = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender: offers the next pending word and predicts each word as it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_event_queue(word_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_on_bus = pending_words[0];
                    pending_words.delete(0);
                    s_tvalid <= 1'b1;
                    s_tuser <= word_on_bus.cmd;
                    s_tdata <= {word_on_bus.enable, word_on_bus.conf, word_on_bus.counts,
                                word_on_bus.mask, word_on_bus.stamp, word_on_bus.frame,
                                word_on_bus.now_ms};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each result word against the oldest prediction.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser[2:0];
                got.beat = m_tuser[3];
                got.seq = m_tdata[31:0];
                got.frame = m_tdata[95:32];
                got.stamp = m_tdata[143:96];
                got.present = m_tdata[159:144];
                got.entered = m_tdata[175:160];
                got.exited = m_tdata[191:176];
                got.counts = m_tdata[255:192];
                got.conf = m_tdata[262:256];
                got.fill = m_tdata[266:263];
                got.drops = m_tdata[298:267];
                if (outcome_words_due.size() == 0) begin
                    report_mismatch("unexpected result word", 64'(m_tuser), 64'h0);
                end else begin
                    want = outcome_words_due[0];
                    outcome_words_due.delete(0);
                    check_field("status", 64'(got.status), 64'(want.status));
                    check_field("is_heartbeat", 64'(got.beat), 64'(want.beat));
                    check_field("sequence_res", 64'(got.seq), 64'(want.seq));
                    check_field("out_frame_number", got.frame, want.frame);
                    check_field("out_timestamp_ms", 64'(got.stamp), 64'(want.stamp));
                    check_field("present_bits", 64'(got.present), 64'(want.present));
                    check_field("entered_bits", 64'(got.entered), 64'(want.entered));
                    check_field("exited_bits", 64'(got.exited), 64'(want.exited));
                    check_field("out_class_counts", got.counts, want.counts);
                    check_field("out_peak_confidence", 64'(got.conf), 64'(want.conf));
                    check_field("queue_fill", 64'(got.fill), 64'(want.fill));
                    check_field("replaced_total", 64'(got.drops), 64'(want.drops));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("presence_event_queue_heartbeat_test: FAIL");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        summary_word_t w;
        int ph;
        int k;
        int left;
        int chunk;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed words: disabled submit, unused command, empty dequeue, double enable.
        queue_word(make_word(CMD_SUBMIT, 32'h0, 16'hFFFF, 1'b1));
        queue_word(make_word(CMD_UNUSED, 32'h1234_5678, 16'hA5A5, 1'b1));
        queue_word(make_word(CMD_DEQUEUE, 32'hFFFF_FFFF, 16'h0, 1'b0));
        queue_word(make_word(CMD_ENABLE, 32'h0, 16'h0, 1'b1));
        queue_word(make_word(CMD_ENABLE, 32'h0, 16'h0, 1'b1));
        // Zero first mask raises nothing; a full mask with all-ones payload is a change.
        queue_word(make_word(CMD_SUBMIT, 32'd0, 16'h0, 1'b0));
        w = make_word(CMD_SUBMIT, 32'd0, 16'hFFFF, 1'b1);
        w.frame = '1;
        w.stamp = '1;
        w.counts = '1;
        w.conf = 7'h7F;
        queue_word(w);
        // One millisecond short of the interval, then exactly on it.
        queue_word(make_word(CMD_SUBMIT, 32'd999, 16'hFFFF, 1'b0));
        w = make_word(CMD_SUBMIT, 32'd1000, 16'hFFFF, 1'b0);
        w.frame = '0;
        w.stamp = '0;
        w.counts = '0;
        w.conf = 7'd0;
        queue_word(w);
        // A change purges the queued heartbeat.
        w = make_word(CMD_SUBMIT, 32'd1001, 16'h0001, 1'b1);
        w.conf = 7'd100;
        queue_word(w);
        repeat (3) queue_word(make_word(CMD_DEQUEUE, 32'd1002, 16'h0, 1'b0));
        // Overfill with changes so the head is evicted.
        for (k = 0; k < 9; k++) begin
            queue_word(make_word(CMD_SUBMIT, 32'(2000 + k),
                                 (k % 2 == 1) ? 16'h0F00 : 16'h00F0, 1'(k)));
        end
        // Heartbeats into a full queue, the second one across the time wrap.
        queue_word(make_word(CMD_SUBMIT, 32'hFFFF_FFFF, 16'h00F0, 1'b1));
        queue_word(make_word(CMD_SUBMIT, 32'd999, 16'h00F0, 1'b0));
        // Disable flushes a full queue.
        queue_word(make_word(CMD_ENABLE, 32'h0, 16'h0, 1'b0));
        gen_enabled = 1'b0;

        // Random phases, each with its own interval and one of four idling patterns.
        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            repeat (8) @(posedge aclk);
            case (ph)
                0: write_interval(16'd0);
                1: write_interval(16'hFFFF);
                2: write_interval(16'd1);
                3: write_interval(16'($urandom));
                4: write_interval(16'($urandom_range(3000, 2)));
                default: write_interval(HB_MS_RESET);
            endcase
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                end
            endcase
            if (ph == 3) begin
                gen_now = 32'hFFFF_C000;
            end
            left = 285;
            while (left > 0) begin
                chunk = $urandom_range(60, 20);
                k = $urandom_range(45, 10);
                repeat (chunk) push_random_word(k);
                left -= chunk;
                // Now and then the sender holds back until every result is in.
                if ($urandom_range(2) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("presence_event_queue_heartbeat_test: PASS");
        end else begin
            $display("presence_event_queue_heartbeat_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== presence_event_queue_heartbeat.f =====
hw/rtl/peqh_pkg.sv
hw/rtl/peqh_ctrl.sv
hw/rtl/peqh_dp.sv
hw/rtl/presence_event_queue_heartbeat.sv
tb/presence_event_queue_heartbeat_test.sv
